/* rtl/ftip_pkg.sv */
`default_nettype none

package ftip_pkg;

    localparam int POS_W    = 13;
    localparam int DIV_W    = 12;
    localparam int GAIN_W   = 24;
    localparam int SPEED_W  = 16;
    localparam int TGT_W    = 9;
    localparam int PERR_W   = 14;
    localparam int NUM_W    = 15;
    localparam int SERR_W   = 18;
    localparam int WORD_W   = 32;
    localparam int PROD_W   = GAIN_W + 1 + SERR_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int ACCS_W   = SUM_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int ST_DEPTH = 3;

    localparam logic [POS_W-1:0]  RST_POSITION_CENTER = 13'd2500;
    localparam logic [DIV_W-1:0]  RST_ERROR_DIVISOR   = 12'd400;
    localparam logic [DIV_W-1:0]  RST_RATE_DIVISOR    = 12'd10;
    localparam logic [GAIN_W-1:0] RST_GAIN_P          = 24'd2162688;
    localparam logic [GAIN_W-1:0] RST_GAIN_I          = 24'd2490;
    localparam logic [GAIN_W-1:0] RST_GAIN_D          = 24'd2621;

    localparam logic [3:0] UNI_CENTER = 4'd6;
    localparam logic [2:0] UNI_LIMIT  = 3'd6;

    typedef logic [POS_W-1:0]          t_pos;
    typedef logic signed [SPEED_W-1:0] t_speed;
    typedef logic [TGT_W-1:0]          t_target;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POSITION_CENTER = 3'd0,
        CFG_ERROR_DIVISOR   = 3'd1,
        CFG_RATE_DIVISOR    = 3'd2,
        CFG_GAIN_P          = 3'd3,
        CFG_GAIN_I          = 3'd4,
        CFG_GAIN_D          = 3'd5
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_LPE = 2'd0,
        ST_LSE = 2'd1,
        ST_ACC = 2'd2
    } t_st_addr;

    typedef struct packed {
        logic              rd_en;
        t_st_addr          rd_addr;
        logic              wr_en;
        t_st_addr          wr_addr;
        logic [WORD_W-1:0] wr_data;
    } t_mem_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LPE,
        S_DIV,
        S_LSE,
        S_MP,
        S_MI,
        S_MD,
        S_SUM,
        S_FIN
    } t_state;

    localparam logic [TGT_W-1:0] TARGET_ROM [0:168] = '{
        9'd203, 9'd211, 9'd211, 9'd211, 9'd226, 9'd226, 9'd230, 9'd230, 9'd228,
        9'd210, 9'd210, 9'd210, 9'd210,
        9'd209, 9'd221, 9'd221, 9'd221, 9'd238, 9'd238, 9'd241, 9'd241, 9'd237,
        9'd231, 9'd231, 9'd231, 9'd227,
        9'd209, 9'd221, 9'd221, 9'd221, 9'd238, 9'd238, 9'd241, 9'd241, 9'd237,
        9'd231, 9'd231, 9'd231, 9'd227,
        9'd209, 9'd221, 9'd221, 9'd221, 9'd238, 9'd238, 9'd241, 9'd241, 9'd237,
        9'd231, 9'd231, 9'd231, 9'd227,
        9'd215, 9'd238, 9'd238, 9'd238, 9'd245, 9'd245, 9'd266, 9'd266, 9'd246,
        9'd237, 9'd237, 9'd237, 9'd232,
        9'd215, 9'd238, 9'd238, 9'd238, 9'd245, 9'd245, 9'd266, 9'd266, 9'd246,
        9'd237, 9'd237, 9'd237, 9'd232,
        9'd218, 9'd250, 9'd250, 9'd250, 9'd276, 9'd276, 9'd283, 9'd283, 9'd280,
        9'd245, 9'd245, 9'd245, 9'd216,
        9'd218, 9'd250, 9'd250, 9'd250, 9'd276, 9'd276, 9'd283, 9'd283, 9'd280,
        9'd245, 9'd245, 9'd245, 9'd216,
        9'd232, 9'd240, 9'd240, 9'd240, 9'd250, 9'd250, 9'd271, 9'd271, 9'd246,
        9'd236, 9'd236, 9'd236, 9'd217,
        9'd226, 9'd230, 9'd230, 9'd230, 9'd236, 9'd236, 9'd239, 9'd239, 9'd236,
        9'd214, 9'd214, 9'd214, 9'd208,
        9'd226, 9'd230, 9'd230, 9'd230, 9'd236, 9'd236, 9'd239, 9'd239, 9'd236,
        9'd214, 9'd214, 9'd214, 9'd208,
        9'd226, 9'd230, 9'd230, 9'd230, 9'd236, 9'd236, 9'd239, 9'd239, 9'd236,
        9'd214, 9'd214, 9'd214, 9'd208,
        9'd211, 9'd211, 9'd211, 9'd211, 9'd226, 9'd226, 9'd230, 9'd230, 9'd228,
        9'd208, 9'd208, 9'd208, 9'd203
    };

    function automatic t_target f_target(input logic [3:0] row, input logic [3:0] col);
        logic [7:0] idx;
        idx = 8'({4'b0, row} * 8'd13) + {4'b0, col};
        return TARGET_ROM[idx];
    endfunction

endpackage

`default_nettype wire

/* rtl/ftip_if.sv */
`default_nettype none

interface ftip_in_if import ftip_pkg::*; ();
    logic   valid;
    logic   ready;
    t_pos   position;
    t_speed measured_speed;
    t_speed speed_latest;
    t_speed speed_before;
    t_speed speed_oldest;

    modport source (output valid, output position, output measured_speed,
                    output speed_latest, output speed_before, output speed_oldest,
                    input ready);
    modport sink   (input valid, input position, input measured_speed,
                    input speed_latest, input speed_before, input speed_oldest,
                    output ready);
endinterface

interface ftip_out_if import ftip_pkg::*; ();
    logic    valid;
    logic    ready;
    t_speed  pwm_drive;
    t_target speed_goal;

    modport source (output valid, output pwm_drive, output speed_goal, input ready);
    modport sink   (input valid, input pwm_drive, input speed_goal, output ready);
endinterface

interface ftip_cfg_if import ftip_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [GAIN_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/ftip_state_mem.sv */
`default_nettype none

module ftip_state_mem import ftip_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_mem_req          i_req,
    output logic [WORD_W-1:0]      o_rd_data
);

    logic [WORD_W-1:0]   r_mem [ST_DEPTH];
    logic [ST_DEPTH-1:0] r_valid;
    logic [WORD_W-1:0]   r_rd_data;
    logic                r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // entries read as zero until first written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

/* rtl/ftip_scale.sv */
`default_nettype none

// round(num / div) half away from zero, clamped to -6..6, as table index 0..12
module ftip_scale import ftip_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [NUM_W-1:0] i_num,
    input  wire logic [DIV_W-1:0]        i_div,
    output logic                         o_done,
    output logic [3:0]                   o_index
);

    localparam int N_W = NUM_W + 1;
    localparam int D_W = DIV_W + 1;

    logic [N_W-1:0]         r_n;
    logic [D_W-1:0]         r_d;
    logic [D_W-1:0]         r_rem;
    logic                   r_neg;
    logic                   r_zero;
    logic                   r_busy;
    logic                   r_done;
    logic [$clog2(N_W)-1:0] r_cnt;

    logic [NUM_W-2:0] mag;
    logic [D_W:0]     rem_sh;
    logic             ge;
    logic [2:0]       qc;

    always_comb begin
        mag    = i_num[NUM_W-1] ? (NUM_W-1)'(-i_num) : (NUM_W-1)'(i_num);
        rem_sh = {r_rem, r_n[N_W-1]};
        ge     = rem_sh >= {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= N_W'({mag, 1'b0}) + N_W'(i_div);
            r_d    <= {i_div, 1'b0};
            r_rem  <= '0;
            r_neg  <= i_num[NUM_W-1];
            r_zero <= (i_num == '0);
        end else if (r_busy) begin
            r_rem <= ge ? D_W'(rem_sh - {1'b0, r_d}) : rem_sh[D_W-1:0];
            r_n   <= {r_n[N_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == ($clog2(N_W))'(N_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(N_W))'(N_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        if (r_zero) begin
            qc = '0;
        end else if (r_n > N_W'(UNI_LIMIT)) begin
            qc = UNI_LIMIT;
        end else begin
            qc = r_n[2:0];
        end
        o_index = r_neg ? UNI_CENTER - {1'b0, qc} : UNI_CENTER + {1'b0, qc};
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

/* rtl/fuzzy_target_incremental_pid.sv */
`default_nettype none

// channel  dir  handshake      word
// i_in     in   valid/ready    position, measured_speed, speed_latest/before/oldest
// o_out    out  valid/ready    pwm_drive, speed_goal
// i_cfg    in   valid/ready    index, data (ready always high)
//
// One word at a time; the next word is accepted only once the state machine is back in idle.
// The two 16-step shift-subtract scalers run side by side;
// the PID terms then go through one 25x18 multiplier in three passes.
// State words (last errors, accumulator) sit in a 3-entry RAM, zero after reset.
// A finished word waits in the output register; a following item stalls in
// its last step only while that register is full and o_out.ready is low.
module fuzzy_target_incremental_pid import ftip_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ftip_in_if.sink   i_in,
    ftip_out_if.source o_out,
    ftip_cfg_if.sink  i_cfg
);

    t_state r_state;
    t_state n_state;

    logic [POS_W-1:0]  r_center;
    logic [DIV_W-1:0]  r_err_div;
    logic [DIV_W-1:0]  r_rate_div;
    logic [GAIN_W-1:0] r_gain_p;
    logic [GAIN_W-1:0] r_gain_i;
    logic [GAIN_W-1:0] r_gain_d;

    t_pos   r_pos;
    t_speed r_speed;
    t_speed r_s0;
    t_speed r_s1;
    t_speed r_s2;

    t_target                   r_target;
    logic signed [SERR_W-1:0]  r_es;
    logic [GAIN_W-1:0]         r_ma;
    logic signed [SERR_W-1:0]  r_mb;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [WORD_W-1:0]  r_acc;

    logic    r_out_valid;
    t_speed  r_pwm;
    t_target r_out_target;

    t_mem_req          mem_req;
    logic [WORD_W-1:0] rd_data;

    logic                      err_done;
    logic                      rate_done;
    logic [3:0]                err_idx;
    logic [3:0]                rate_idx;
    logic                      div_start;
    logic                      fin_go;

    logic signed [PERR_W-1:0]  ep;
    logic signed [NUM_W-1:0]   dep;
    t_target                   tgt;
    logic signed [SERR_W-1:0]  es_c;
    logic signed [SERR_W-1:0]  lse;
    logic signed [SERR_W-1:0]  d2;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACCS_W-1:0]  acc_sum;
    logic [WORD_W-1:0]         sat;
    logic [WORD_W:0]           rnd;

    ftip_state_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    ftip_scale u_err_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (NUM_W'(ep)),
        .i_div   (r_err_div),
        .o_done  (err_done),
        .o_index (err_idx)
    );

    ftip_scale u_rate_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (dep),
        .i_div   (r_rate_div),
        .o_done  (rate_done),
        .o_index (rate_idx)
    );

    always_comb begin
        ep   = $signed({1'b0, r_center}) - $signed({1'b0, r_pos});
        dep  = $signed({ep[PERR_W-1], ep}) - $signed(rd_data[NUM_W-1:0]);
        tgt  = f_target(err_idx, rate_idx);
        es_c = $signed({{(SERR_W-TGT_W){1'b0}}, tgt})
             - $signed({{(SERR_W-SPEED_W){r_speed[SPEED_W-1]}}, r_speed});
        lse  = $signed(rd_data[SERR_W-1:0]);
        d2   = $signed({{(SERR_W-SPEED_W){r_s0[SPEED_W-1]}}, r_s0})
             - $signed({r_s1[SPEED_W-1], r_s1, 1'b0})
             + $signed({{(SERR_W-SPEED_W){r_s2[SPEED_W-1]}}, r_s2});
        prod = $signed({1'b0, r_ma}) * r_mb;
        acc_sum = $signed({{(ACCS_W-WORD_W){r_acc[WORD_W-1]}}, r_acc})
                + $signed({r_sum[SUM_W-1], r_sum});
        if (acc_sum[ACCS_W-1:WORD_W-1] == '0 || acc_sum[ACCS_W-1:WORD_W-1] == '1) begin
            sat = acc_sum[WORD_W-1:0];
        end else if (acc_sum[ACCS_W-1]) begin
            sat = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(WORD_W-1){1'b1}}};
        end
        // truncate toward zero
        rnd = {sat[WORD_W-1], sat} + (sat[WORD_W-1] ? (WORD_W+1)'(16'hFFFF) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        mem_req   = '{rd_en: 1'b0, rd_addr: ST_LPE, wr_en: 1'b0, wr_addr: ST_LPE,
                      wr_data: '0};
        div_start = 1'b0;
        fin_go    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ST_LPE;
                    n_state         = S_LPE;
                end
            end
            S_LPE: begin
                div_start       = 1'b1;
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = ST_LPE;
                mem_req.wr_data = WORD_W'(ep);
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (err_done && rate_done) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ST_LSE;
                    n_state         = S_LSE;
                end
            end
            S_LSE: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = ST_LSE;
                mem_req.wr_data = WORD_W'(r_es);
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ST_ACC;
                n_state         = S_MP;
            end
            S_MP:  n_state = S_MI;
            S_MI:  n_state = S_MD;
            S_MD:  n_state = S_SUM;
            S_SUM: n_state = S_FIN;
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    fin_go          = 1'b1;
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = ST_ACC;
                    mem_req.wr_data = sat;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    r_pos   <= i_in.position;
                    r_speed <= i_in.measured_speed;
                    r_s0    <= i_in.speed_latest;
                    r_s1    <= i_in.speed_before;
                    r_s2    <= i_in.speed_oldest;
                end
            end
            S_DIV: begin
                if (err_done && rate_done) begin
                    r_target <= tgt;
                    r_es     <= es_c;
                end
            end
            S_LSE: begin
                r_ma <= r_gain_p;
                r_mb <= r_es - lse;
            end
            S_MP: begin
                r_acc  <= $signed(rd_data);
                r_prod <= prod;
                r_ma   <= r_gain_i;
                r_mb   <= r_es;
            end
            S_MI: begin
                r_sum  <= $signed({r_prod[PROD_W-1], r_prod});
                r_prod <= prod;
                r_ma   <= r_gain_d;
                r_mb   <= d2;
            end
            S_MD: begin
                r_sum  <= r_sum + $signed({r_prod[PROD_W-1], r_prod});
                r_prod <= prod;
            end
            S_SUM: begin
                r_sum <= r_sum - $signed({r_prod[PROD_W-1], r_prod});
            end
            S_FIN: begin
                if (fin_go) begin
                    r_pwm        <= $signed(rnd[WORD_W-1:16]);
                    r_out_target <= r_target;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_go) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center   <= RST_POSITION_CENTER;
            r_err_div  <= RST_ERROR_DIVISOR;
            r_rate_div <= RST_RATE_DIVISOR;
            r_gain_p   <= RST_GAIN_P;
            r_gain_i   <= RST_GAIN_I;
            r_gain_d   <= RST_GAIN_D;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_POSITION_CENTER: r_center   <= i_cfg.data[POS_W-1:0];
                CFG_ERROR_DIVISOR:   r_err_div  <= i_cfg.data[DIV_W-1:0];
                CFG_RATE_DIVISOR:    r_rate_div <= i_cfg.data[DIV_W-1:0];
                CFG_GAIN_P:          r_gain_p   <= i_cfg.data;
                CFG_GAIN_I:          r_gain_i   <= i_cfg.data;
                CFG_GAIN_D:          r_gain_d   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_out_valid;
    assign o_out.pwm_drive  = r_pwm;
    assign o_out.speed_goal = r_out_target;

endmodule

`default_nettype wire
